// ===== hw/rtl/ftn_amp_pkg.sv =====
package ftn_amp_pkg;

    localparam int CHAR_W      = 8;
    localparam int WORD_W      = 16;
    localparam int DIGIT_W     = 4;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 72;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;

    localparam logic [WORD_W-1:0] WORD_ANY     = 16'hFFFF;
    localparam logic [WORD_W-1:0] NODE_REGION  = 16'hFFFE;
    localparam logic [WORD_W-1:0] REGION_LIMIT = 16'd100;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [3:0] {
        PH_START,
        PH_NET_DIG,
        PH_NET_SKIP,
        PH_NODE_START,
        PH_NODE_DIG,
        PH_NODE_SKIP,
        PH_PT_START,
        PH_PT_DIG,
        PH_PT_DONE
    } t_phase;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } t_char_item;

    typedef struct packed {
        t_phase phase;
        t_word  net;
        t_word  node;
        t_word  point;
    } t_seg_state;

    typedef struct packed {
        logic  status;
        t_word zone;
        t_word net;
        t_word node;
        t_word point;
    } t_result;

    // acc * 10 + d, wrapping at 16 bits
    function automatic t_word add_digit(t_word acc, logic [DIGIT_W-1:0] d);
        t_word sum;
        sum = (acc << 3) + (acc << 1) + {{(WORD_W-DIGIT_W){1'b0}}, d};
        return sum;
    endfunction

    function automatic logic is_digit(logic [CHAR_W-1:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_of(logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] diff;
        diff = ch - CH_ZERO;
        return diff[DIGIT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/ftn_amp_in_reg.sv =====
module ftn_amp_in_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_tvalid,
    input  logic [7:0]             i_tdata,
    input  logic                   i_tlast,
    input  logic                   i_advance,
    output logic                   o_tready,
    output logic                   o_valid,
    output ftn_amp_pkg::t_char_item o_item
);
    import ftn_amp_pkg::*;

    logic       r_valid;
    logic       n_valid;
    t_char_item r_item;
    logic       load;

    assign o_tready = !r_valid || i_advance;
    assign load     = i_tvalid && o_tready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.character <= i_tdata[CHAR_W-1:0];
            r_item.last_char <= i_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/ftn_amp_seg.sv =====
module ftn_amp_seg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_feed,
    input  logic                    i_clear,
    input  logic [7:0]              i_character,
    output ftn_amp_pkg::t_seg_state o_cur,
    output ftn_amp_pkg::t_seg_state o_next
);
    import ftn_amp_pkg::*;

    t_seg_state        r_seg;
    t_seg_state        n_seg;
    logic              dig;
    logic [DIGIT_W-1:0] d;

    assign dig = is_digit(i_character);
    assign d   = dig ? digit_of(i_character) : '0;

    always_comb begin
        n_seg = r_seg;
        if (i_feed) begin
            case (r_seg.phase)
                PH_START, PH_NET_DIG: begin
                    if (dig) begin
                        n_seg.net   = (r_seg.phase == PH_START) ?
                                      {{(WORD_W-DIGIT_W){1'b0}}, d} : add_digit(r_seg.net, d);
                        n_seg.phase = PH_NET_DIG;
                    end else if (i_character == CH_SLASH) begin
                        n_seg.phase = PH_NODE_START;
                    end else begin
                        n_seg.phase = PH_NET_SKIP;
                    end
                end
                PH_NET_SKIP: begin
                    if (i_character == CH_SLASH) n_seg.phase = PH_NODE_START;
                end
                PH_NODE_START, PH_NODE_DIG: begin
                    if (dig) begin
                        n_seg.node  = (r_seg.phase == PH_NODE_START) ?
                                      {{(WORD_W-DIGIT_W){1'b0}}, d} : add_digit(r_seg.node, d);
                        n_seg.phase = PH_NODE_DIG;
                    end else if (i_character == CH_DOT) begin
                        n_seg.phase = PH_PT_START;
                    end else begin
                        n_seg.phase = PH_NODE_SKIP;
                    end
                end
                PH_NODE_SKIP: begin
                    if (i_character == CH_DOT) n_seg.phase = PH_PT_START;
                end
                PH_PT_START: begin
                    if (dig) begin
                        n_seg.point = {{(WORD_W-DIGIT_W){1'b0}}, d};
                        n_seg.phase = PH_PT_DIG;
                    end else begin
                        n_seg.point = '0;
                        n_seg.phase = PH_PT_DONE;
                    end
                end
                PH_PT_DIG: begin
                    if (dig) n_seg.point = add_digit(r_seg.point, d);
                    else     n_seg.phase = PH_PT_DONE;
                end
                default: begin
                    n_seg = r_seg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_seg.phase <= PH_START;
            r_seg.net   <= '0;
            r_seg.node  <= '0;
            r_seg.point <= WORD_ANY;
        end else begin
            r_seg <= n_seg;
        end
    end

    assign o_cur  = r_seg;
    assign o_next = n_seg;

endmodule

// ===== hw/rtl/ftn_amp_core.sv =====
module ftn_amp_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [15:0]             i_cfg_wr_data,
    input  logic                    i_step,
    input  ftn_amp_pkg::t_char_item i_item,
    output logic                    o_res_valid,
    output ftn_amp_pkg::t_result    o_result
);
    import ftn_amp_pkg::*;

    t_word r_default_zone;
    logic  r_stopped,  n_stopped;
    logic  r_nonempty, n_nonempty;
    logic  r_colon,    n_colon;
    logic  r_star,     n_star;
    t_word r_lead,     n_lead;

    logic        [CHAR_W-1:0] ch;
    logic        dig;
    logic        prefix_ch;
    logic        feed_any;
    logic        clear;
    t_seg_state  seg_cur  [2];
    t_seg_state  seg_next [2];
    t_seg_state  sel;

    assign ch        = i_item.character;
    assign dig       = is_digit(ch);
    assign prefix_ch = dig || ch == CH_COLON || ch == CH_SLASH || ch == CH_DOT || ch == CH_STAR;
    assign feed_any  = i_step && !r_stopped && prefix_ch && ch != CH_STAR &&
                       !(ch == CH_COLON && !r_colon);
    assign clear     = i_step && i_item.last_char;

    ftn_amp_seg u_seg0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_feed      (feed_any && !r_colon),
        .i_clear     (clear),
        .i_character (ch),
        .o_cur       (seg_cur[0]),
        .o_next      (seg_next[0])
    );

    ftn_amp_seg u_seg1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_feed      (feed_any && r_colon),
        .i_clear     (clear),
        .i_character (ch),
        .o_cur       (seg_cur[1]),
        .o_next      (seg_next[1])
    );

    always_comb begin
        n_stopped  = r_stopped;
        n_nonempty = r_nonempty;
        n_colon    = r_colon;
        n_star     = r_star;
        n_lead     = r_lead;
        if (i_step && !r_stopped) begin
            if (!prefix_ch) begin
                n_stopped = 1'b1;
            end else begin
                if (dig && !r_colon && !r_nonempty) begin
                    n_lead = {{(WORD_W-DIGIT_W){1'b0}}, digit_of(ch)};
                end else if (dig && !r_colon && seg_cur[0].phase == PH_NET_DIG) begin
                    n_lead = add_digit(r_lead, digit_of(ch));
                end
                n_nonempty = 1'b1;
                if (ch == CH_STAR) begin
                    n_star    = 1'b1;
                    n_stopped = 1'b1;
                end else if (ch == CH_COLON && !r_colon) begin
                    n_colon = 1'b1;
                end
            end
        end
    end

    // result from the state after this character
    always_comb begin
        sel             = n_colon ? seg_next[1] : seg_next[0];
        o_result.status = 1'b0;
        o_result.zone   = n_colon ? n_lead : r_default_zone;
        o_result.net    = WORD_ANY;
        o_result.node   = WORD_ANY;
        o_result.point  = WORD_ANY;
        if (!n_nonempty) begin
            o_result.status = 1'b1;
            o_result.zone   = r_default_zone;
        end else if (sel.phase == PH_START && n_star) begin
            if (!n_colon) o_result.zone = WORD_ANY;
        end else if (sel.phase == PH_START || sel.phase == PH_NET_DIG ||
                     sel.phase == PH_NET_SKIP) begin
            if (!n_star) begin
                o_result.status = 1'b1;
            end else begin
                o_result.net = sel.net;
                if (sel.net >= REGION_LIMIT) o_result.status = 1'b1;
                else                         o_result.node   = NODE_REGION;
            end
        end else begin
            o_result.net = sel.net;
            if (!(sel.phase == PH_NODE_START && n_star)) begin
                o_result.node = sel.node;
                if (sel.phase == PH_PT_START) begin
                    o_result.point = n_star ? WORD_ANY : '0;
                end else if (sel.phase == PH_PT_DIG || sel.phase == PH_PT_DONE) begin
                    o_result.point = sel.point;
                end
            end
        end
    end

    assign o_res_valid = clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_zone <= '0;
        end else if (i_cfg_wr_en) begin
            r_default_zone <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_stopped  <= 1'b0;
            r_nonempty <= 1'b0;
            r_colon    <= 1'b0;
            r_star     <= 1'b0;
            r_lead     <= '0;
        end else begin
            r_stopped  <= n_stopped;
            r_nonempty <= n_nonempty;
            r_colon    <= n_colon;
            r_star     <= n_star;
            r_lead     <= n_lead;
        end
    end

    a_region_net_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_result.status && o_result.node == NODE_REGION
        |-> o_result.net < REGION_LIMIT)
        else $error("region mask with net of 100 or more");

    a_star_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_star |-> r_stopped && r_nonempty)
        else $error("star seen but scan still running");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |=> !r_colon && !r_nonempty && !r_stopped)
        else $error("parser not cleared after result");

    a_one_seg_fed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_colon |-> seg_next[0] == seg_cur[0] || clear)
        else $error("first segment parser moved after colon");

endmodule

// ===== hw/rtl/ftn_amp_out_reg.sv =====
module ftn_amp_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ftn_amp_pkg::t_result i_result,
    input  logic                 i_tready,
    output logic                 o_tvalid,
    output logic [71:0]          o_tdata
);
    import ftn_amp_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_result <= i_result;
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {{(TDATA_OUT_W-1-4*WORD_W){1'b0}},
                       r_result.point, r_result.node, r_result.net,
                       r_result.zone, r_result.status};

endmodule

// ===== hw/rtl/ftn_address_mask_parser.sv =====
// A last character passes the input register, and its result the result register, on its way to m_axis.
// Throughput: one character per cycle; the input and result registers part the sides.
// A held result stalls only a following last character, other characters flow on.
// Reset (i_rst_n low, synchronous): parser state cleared, default_zone set to 0,
// both stream registers emptied.
module ftn_address_mask_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // [0] status, [16:1] zone_out, [32:17] net_out,
                                        // [48:33] node_out, [64:49] point_out, rest zero
);
    import ftn_amp_pkg::*;

    logic       in_valid;
    t_char_item in_item;
    logic       advance;
    logic       res_valid;
    t_result    result;

    // a last character may only move on when the result register is free
    assign advance = in_valid &&
                     (!in_item.last_char || !m_axis_tvalid || m_axis_tready);

    ftn_amp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .i_tdata   (s_axis_tdata),
        .i_tlast   (s_axis_tlast),
        .i_advance (advance),
        .o_tready  (s_axis_tready),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    ftn_amp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (advance),
        .i_item        (in_item),
        .o_res_valid   (res_valid),
        .o_result      (result)
    );

    ftn_amp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (result),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !res_valid)
        else $error("result overwritten while held");

    a_last_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_item.last_char && m_axis_tvalid && !m_axis_tready
        |-> !s_axis_tready)
        else $error("input taken while last character is blocked");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> m_axis_tvalid)
        else $error("result lost");

endmodule

// ===== tb/tb_ftn_address_mask_parser.sv =====
`timescale 1ns / 1ps

module tb_ftn_address_mask_parser;

    import ftn_amp_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CHARS_PER_ZONE = 500;

    // Tracks the parse of the current mask and holds the decoded addresses still due.
    class mask_scoreboard;
        t_word   zone_default;
        bit      scan_done;
        bit      saw_prefix;
        bit      saw_colon;
        bit      saw_star;
        t_word   zone_digits;
        t_phase  seg_phase [2];
        t_word   seg_net   [2];
        t_word   seg_node  [2];
        t_word   seg_point [2];
        t_result expected_masks [$];
        int      fail_count;

        function new();
            zone_default = '0;
            fail_count   = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            scan_done   = 1'b0;
            saw_prefix  = 1'b0;
            saw_colon   = 1'b0;
            saw_star    = 1'b0;
            zone_digits = '0;
            for (int i = 0; i < 2; i++) begin
                seg_phase[i] = PH_START;
                seg_net[i]   = '0;
                seg_node[i]  = '0;
                seg_point[i] = WORD_ANY;
            end
        endfunction

        function t_word shift_in(t_word acc, logic [3:0] d);
            logic [31:0] wide;
            wide = acc * 32'd10 + d;
            return wide[15:0];
        endfunction

        function void note_char(logic [7:0] ch, logic last);
            logic       dig;
            logic [7:0] diff;
            logic [3:0] d;
            int         k;
            t_phase     ph;
            t_result    r;
            dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
            diff = ch - CH_ZERO;
            d    = diff[3:0];
            if (!scan_done) begin
                if (!(dig || ch == CH_COLON || ch == CH_SLASH || ch == CH_DOT || ch == CH_STAR)) begin
                    scan_done = 1'b1;
                end else begin
                    // zone number only grows while the first segment is still on net digits
                    if (dig && !saw_colon && !saw_prefix)
                        zone_digits = {12'b0, d};
                    else if (dig && !saw_colon && seg_phase[0] == PH_NET_DIG)
                        zone_digits = shift_in(zone_digits, d);
                    saw_prefix = 1'b1;
                    if (ch == CH_STAR) begin
                        saw_star  = 1'b1;
                        scan_done = 1'b1;
                    end else if (ch == CH_COLON && !saw_colon) begin
                        saw_colon = 1'b1;
                    end else begin
                        k = saw_colon ? 1 : 0;
                        case (seg_phase[k])
                            PH_START, PH_NET_DIG: begin
                                if (dig) begin
                                    seg_net[k]   = (seg_phase[k] == PH_START) ? {12'b0, d}
                                                                                : shift_in(seg_net[k], d);
                                    seg_phase[k] = PH_NET_DIG;
                                end else if (ch == CH_SLASH) begin
                                    seg_phase[k] = PH_NODE_START;
                                end else begin
                                    seg_phase[k] = PH_NET_SKIP;
                                end
                            end
                            PH_NET_SKIP: begin
                                if (ch == CH_SLASH)
                                    seg_phase[k] = PH_NODE_START;
                            end
                            PH_NODE_START, PH_NODE_DIG: begin
                                if (dig) begin
                                    seg_node[k]  = (seg_phase[k] == PH_NODE_START) ? {12'b0, d}
                                                                                     : shift_in(seg_node[k], d);
                                    seg_phase[k] = PH_NODE_DIG;
                                end else if (ch == CH_DOT) begin
                                    seg_phase[k] = PH_PT_START;
                                end else begin
                                    seg_phase[k] = PH_NODE_SKIP;
                                end
                            end
                            PH_NODE_SKIP: begin
                                if (ch == CH_DOT)
                                    seg_phase[k] = PH_PT_START;
                            end
                            PH_PT_START: begin
                                seg_point[k] = dig ? {12'b0, d} : '0;
                                seg_phase[k] = dig ? PH_PT_DIG : PH_PT_DONE;
                            end
                            PH_PT_DIG: begin
                                if (dig)
                                    seg_point[k] = shift_in(seg_point[k], d);
                                else
                                    seg_phase[k] = PH_PT_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            if (last) begin
                k        = saw_colon ? 1 : 0;
                ph       = seg_phase[k];
                r.status = 1'b0;
                r.zone   = saw_colon ? zone_digits : zone_default;
                r.net    = WORD_ANY;
                r.node   = WORD_ANY;
                r.point  = WORD_ANY;
                if (!saw_prefix) begin
                    r.status = 1'b1;
                    r.zone   = zone_default;
                end else if (ph == PH_START && saw_star) begin
                    if (!saw_colon)
                        r.zone = WORD_ANY;
                end else if (ph == PH_START || ph == PH_NET_DIG || ph == PH_NET_SKIP) begin
                    // net only: legal solely as a region mask ending in a star
                    if (!saw_star) begin
                        r.status = 1'b1;
                    end else begin
                        r.net = seg_net[k];
                        if (r.net >= REGION_LIMIT)
                            r.status = 1'b1;
                        else
                            r.node = NODE_REGION;
                    end
                end else begin
                    r.net = seg_net[k];
                    if (!(ph == PH_NODE_START && saw_star)) begin
                        r.node = seg_node[k];
                        if (ph == PH_PT_START)
                            r.point = saw_star ? WORD_ANY : '0;
                        else if (ph == PH_PT_DIG || ph == PH_PT_DONE)
                            r.point = seg_point[k];
                    end
                end
                expected_masks.push_back(r);
                clear_parse();
            end
        endfunction

        function void compare_field(string tag, t_word want, t_word got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, tag, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(logic st, t_word zone, t_word net, t_word node, t_word point);
            t_result want;
            if (expected_masks.size() == 0) begin
                $display("%0t: unexpected result, got status %b zone %h net %h node %h point %h",
                         $time, st, zone, net, node, point);
                fail_count++;
            end else begin
                want = expected_masks.pop_front();
                compare_field("status", {15'b0, want.status}, {15'b0, st});
                compare_field("zone", want.zone, zone);
                compare_field("net", want.net, net);
                compare_field("node", want.node, node);
                compare_field("point", want.point, point);
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_wr_en    = 1'b0;
    logic [15:0] i_cfg_wr_data  = '0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata   = '0;
    logic        s_axis_tlast   = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [71:0] m_axis_tdata;

    mask_scoreboard board = new();
    bit             calm;
    int             stall_left;
    int             idle_cycles;

    ftn_address_mask_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] prefix_char();
        case ($urandom_range(0, 4))
            0:       return CH_COLON;
            1:       return CH_SLASH;
            2:       return CH_DOT;
            3:       return CH_STAR;
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic void push_digits(ref logic [7:0] m [$]);
        int n;
        // occasionally long enough to wrap past 16 bits
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
        repeat (n) m.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void make_mask(ref logic [7:0] m [$]);
        int n;
        int form;
        m.delete();
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) m.push_back($urandom_range(0, 1) ? prefix_char() : 8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 1)) begin
                push_digits(m);
                m.push_back(CH_COLON);
            end
            form = $urandom_range(0, 9);
            if (form == 0) begin
                m.push_back(CH_STAR);
            end else if (form <= 3) begin
                push_digits(m);
                m.push_back(CH_STAR);
            end else begin
                push_digits(m);
                m.push_back(CH_SLASH);
                if ($urandom_range(0, 4) == 0) begin
                    m.push_back(CH_STAR);
                end else begin
                    push_digits(m);
                    if ($urandom_range(0, 1)) begin
                        m.push_back(CH_DOT);
                        if ($urandom_range(0, 3) == 0)
                            m.push_back(CH_STAR);
                        else
                            push_digits(m);
                    end
                end
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) m.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_char(logic [7:0] ch, logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_char(ch, last);
    endtask

    task automatic send_mask(logic [7:0] m [$]);
        calm = ($urandom_range(0, 5) == 0);
        foreach (m[i])
            send_char(m[i], i == m.size() - 1);
    endtask

    task automatic send_text(string s);
        logic [7:0] m [$];
        for (int i = 0; i < s.len(); i++)
            m.push_back(s[i]);
        send_mask(m);
    endtask

    // only while the parser is empty; lets the pipeline drain first
    task automatic set_default_zone(t_word value);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.expected_masks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        board.zone_default = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[32:17],
                               m_axis_tdata[48:33], m_axis_tdata[64:49]);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_word      zones [4];
        logic [7:0] m [$];
        int         sent;
        zones[0] = 16'hFFFF;
        zones[1] = 16'h0000;
        zones[2] = 16'($urandom_range(1, 16'hFFFE));
        zones[3] = 16'($urandom_range(1, 16'hFFFE));
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_default_zone(zones[0]);
        // directed: bare star, empty prefixes, region limits, full and partial addresses
        send_text("*");
        m = {8'hFF};
        send_mask(m);
        m = {8'h00};
        send_mask(m);
        send_text("99*");
        send_text("100*");
        send_text("1:2/3.4");
        send_text("5/.");
        send_text("7");
        send_text("3:*");

        for (int p = 0; p < 4; p++) begin
            if (p > 0)
                set_default_zone(zones[p]);
            sent = 0;
            while (sent < CHARS_PER_ZONE) begin
                make_mask(m);
                send_mask(m);
                sent += m.size();
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.expected_masks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
